// ===== sv/sib_pkg.sv =====
// Shared types and constants of the smart interframe blend block.
`default_nettype none
package sib_pkg;

   localparam int PIXEL_W = 32;
   localparam int WIDTH_W = 8;
   localparam int HEIGHT_W = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_INDEX_W-1:0] REG_VISIBLE_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_VISIBLE_HEIGHT = 2'd1;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 8'd240;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 9'd160;

   localparam logic [PIXEL_W-1:0] BLEND_MASK = 32'h00fe_fefe;

   localparam int NUM_STORES = 3;

   // Rotation phase: the store that holds the frame of one frame ago.
   typedef logic [1:0] phase_type;
   localparam phase_type PHASE_A = 2'd0;
   localparam phase_type PHASE_B = 2'd1;
   localparam phase_type PHASE_C = 2'd2;

   // Write control from the pipeline to the frame stores.
   typedef struct packed {
      logic                  clear;
      logic [NUM_STORES-1:0] store_we;
   } wr_ctl_type;

   // Phase after the last pixel of a frame.
   function automatic phase_type next_phase(input phase_type p);
      phase_type r;
      case (p)
         PHASE_A: r = PHASE_B;
         PHASE_B: r = PHASE_C;
         default: r = PHASE_A;
      endcase
      return r;
   endfunction

   // One-hot select of the oldest store, the one that is overwritten.
   function automatic logic [NUM_STORES-1:0] oldest_store(input phase_type p);
      logic [NUM_STORES-1:0] r;
      case (p)
         PHASE_B: r = 3'b100;
         PHASE_C: r = 3'b001;
         default: r = 3'b010;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/sib_req_if.sv =====
// Input pixel channel of the smart interframe blend block.
`default_nettype none
interface sib_req_if;
   logic                         valid;
   logic                         ready;
   logic [sib_pkg::PIXEL_W-1:0]  pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink (input valid, input pixel_in, output ready);
endinterface
`default_nettype wire

// ===== sv/sib_rsp_if.sv =====
// Result pixel channel of the smart interframe blend block.
`default_nettype none
interface sib_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sib_pkg::PIXEL_W-1:0]  pixel_out;
   logic                         blended;
   logic                         frame_end;

   modport source (output valid, output pixel_out, output blended, output frame_end,
                   input ready);
   modport sink (input valid, input pixel_out, input blended, input frame_end,
                 output ready);
endinterface
`default_nettype wire

// ===== sv/smart_interframe_blend.sv =====
// Top level of the smart interframe blend block: flicker suppression over a pixel stream.
//
//   Port      Direction  Handshake      Payload
//   req_if    in         valid/ready    pixel_in
//   rsp_if    out        valid/ready    pixel_out, blended, frame_end
//   csr_*     in         csr_we only    csr_index, csr_wdata
//
// One pixel per clock is sustained while rsp_if does not stall; a result passes from
// the compare stage, which takes the frame-store read data, to the output register.
// After reset a clearing pass zeroes every entry of the stores, during which
// req_if.ready is low. A stall on rsp_if holds the pipeline; the input side keeps
// taking pixels until both the compare stage and the output register are full.
`default_nettype none
module smart_interframe_blend #(
   parameter int MAX_PIXELS = 65536
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   sib_req_if.sink                                  req_if,
   sib_rsp_if.source                                rsp_if,
   input  wire logic                                csr_we,
   input  wire logic [sib_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [sib_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AddrW = $clog2(MAX_PIXELS);
   localparam int LenW = (AddrW + 1 > 17) ? AddrW + 1 : 17;

   // Configuration.
   logic [sib_pkg::WIDTH_W-1:0]  width_ff;
   logic [sib_pkg::HEIGHT_W-1:0] height_ff;

   // Clearing pass.
   logic             clear_ff;
   logic [AddrW-1:0] clear_addr_ff;
   logic             clear_done;

   // Frame position and store rotation.
   logic [AddrW-1:0]           pos_ff;
   logic [AddrW-1:0]           pos_in;
   sib_pkg::phase_type         phase_ff;
   sib_pkg::phase_type         phase_in;
   logic [LenW-1:0]            prod;
   logic [LenW-1:0]            len_sat;
   logic [AddrW-1:0]           len_m1;
   logic [AddrW-1:0]           eff_pos;
   logic                       last;
   logic                       accept;

   // Compare stage.
   logic                          s1_valid_ff;
   logic [sib_pkg::PIXEL_W-1:0]   s1_pixel_ff;
   logic [AddrW-1:0]              s1_pos_ff;
   sib_pkg::phase_type            s1_phase_ff;
   logic                          s1_last_ff;
   logic                          s1_adv;

   // Output register.
   logic                          out_valid_ff;
   logic [sib_pkg::PIXEL_W-1:0]   out_pixel_ff;
   logic                          out_blended_ff;
   logic                          out_last_ff;

   // Store access.
   sib_pkg::wr_ctl_type                                   wr_ctl;
   logic [AddrW-1:0]                                      wr_addr;
   logic [sib_pkg::NUM_STORES-1:0][sib_pkg::PIXEL_W-1:0]  rd_data;
   logic [sib_pkg::PIXEL_W-1:0]                           f1;
   logic [sib_pkg::PIXEL_W-1:0]                           f2;
   logic [sib_pkg::PIXEL_W-1:0]                           f3;
   logic                                                  flick;
   logic [sib_pkg::PIXEL_W-1:0]                           blend;

   // Frame length, saturated to the store depth; a zero product counts as one pixel.
   always_comb begin
      prod = (LenW'(width_ff) + LenW'(1)) * LenW'(height_ff);
      if (prod == '0) begin
         len_sat = LenW'(1);
      end else if (prod > LenW'(MAX_PIXELS)) begin
         len_sat = LenW'(MAX_PIXELS);
      end else begin
         len_sat = prod;
      end
      len_m1 = AddrW'(len_sat - LenW'(1));
   end

   // A position left past the frame by a register write is taken as the last pixel.
   assign last = (pos_ff >= len_m1);
   assign eff_pos = last ? len_m1 : pos_ff;
   assign pos_in = last ? '0 : eff_pos + AddrW'(1);
   assign phase_in = last ? sib_pkg::next_phase(phase_ff) : phase_ff;

   assign s1_adv = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = !clear_ff && (!s1_valid_ff || s1_adv);
   assign accept = req_if.valid && req_if.ready;
   assign clear_done = (clear_addr_ff == AddrW'(MAX_PIXELS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= sib_pkg::WIDTH_RESET;
         height_ff <= sib_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            sib_pkg::REG_VISIBLE_WIDTH: width_ff <= csr_wdata[sib_pkg::WIDTH_W-1:0];
            sib_pkg::REG_VISIBLE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + AddrW'(1);
         if (clear_done) begin
            clear_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         phase_ff <= sib_pkg::PHASE_A;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff <= pos_in;
            phase_ff <= phase_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         s1_pixel_ff <= req_if.pixel_in;
         s1_pos_ff <= eff_pos;
         s1_phase_ff <= phase_ff;
         s1_last_ff <= last;
      end
   end

   // Store roles: the phase names the store of one frame ago; the next one in
   // rotation holds three frames ago and the one after that two frames ago.
   always_comb begin
      case (s1_phase_ff)
         sib_pkg::PHASE_B: begin
            f1 = rd_data[1];
            f2 = rd_data[0];
            f3 = rd_data[2];
         end
         sib_pkg::PHASE_C: begin
            f1 = rd_data[2];
            f2 = rd_data[1];
            f3 = rd_data[0];
         end
         default: begin
            f1 = rd_data[0];
            f2 = rd_data[2];
            f3 = rd_data[1];
         end
      endcase
      flick = (f1 != f2) && (f3 != s1_pixel_ff) && ((s1_pixel_ff == f2) || (f1 == f3));
      blend = ((s1_pixel_ff & sib_pkg::BLEND_MASK) >> 1) + ((f1 & sib_pkg::BLEND_MASK) >> 1);
   end

   always_comb begin
      wr_ctl.clear = clear_ff;
      wr_ctl.store_we = (s1_valid_ff && s1_adv) ? sib_pkg::oldest_store(s1_phase_ff) : '0;
      wr_addr = clear_ff ? clear_addr_ff : s1_pos_ff;
   end

   sib_history #(
      .Depth (MAX_PIXELS),
      .AddrW (AddrW)
   ) u_history (
      .clock   (clock),
      .reset   (reset),
      .wr_ctl  (wr_ctl),
      .wr_addr (wr_addr),
      .wr_data (s1_pixel_ff),
      .rd_en   (accept),
      .rd_addr (eff_pos),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= s1_valid_ff;
      end
      if (s1_adv && s1_valid_ff) begin
         out_pixel_ff <= flick ? blend : s1_pixel_ff;
         out_blended_ff <= flick;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.pixel_out = out_pixel_ff;
   assign rsp_if.blended = out_blended_ff;
   assign rsp_if.frame_end = out_last_ff;

   a_clear_length: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_ff) |-> $past(clear_addr_ff) == AddrW'(MAX_PIXELS - 1))
      else $error("clearing pass ended early");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> pos_ff == '0 && phase_ff != $past(phase_ff))
      else $error("frame end did not wrap position and rotate stores");

   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      accept && !last |=> pos_ff == $past(eff_pos) + AddrW'(1) && $stable(phase_ff))
      else $error("position did not advance by one");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_pixel_ff) && $stable(s1_pos_ff))
      else $error("stalled compare stage lost its pixel");

   a_s1_to_out: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_adv |=> out_valid_ff)
      else $error("compared pixel did not reach the output register");

endmodule
`default_nettype wire

// ===== sv/sib_history.sv =====
// Three frame stores with a shared read address and write-to-read forwarding.
`default_nettype none
module sib_history #(
   parameter int Depth = 65536,
   parameter int AddrW = 16
) (
   input  wire logic                                               clock,
   input  wire logic                                               reset,
   input  wire sib_pkg::wr_ctl_type                                wr_ctl,
   input  wire logic [AddrW-1:0]                                   wr_addr,
   input  wire logic [sib_pkg::PIXEL_W-1:0]                        wr_data,
   input  wire logic                                               rd_en,
   input  wire logic [AddrW-1:0]                                   rd_addr,
   output logic [sib_pkg::NUM_STORES-1:0][sib_pkg::PIXEL_W-1:0]    rd_data
);

   logic [sib_pkg::NUM_STORES-1:0]                      we;
   logic [sib_pkg::PIXEL_W-1:0]                         store_data;
   logic [sib_pkg::NUM_STORES-1:0][sib_pkg::PIXEL_W-1:0] q_ff;
   logic [sib_pkg::NUM_STORES-1:0]                      hit_ff;
   logic [sib_pkg::NUM_STORES-1:0]                      hit_in;
   logic [sib_pkg::PIXEL_W-1:0]                         fwd_data_ff;

   // Each word holds the same position of all three stores, one lane per store.
   logic [sib_pkg::NUM_STORES-1:0][sib_pkg::PIXEL_W-1:0] mem [Depth];

   assign store_data = wr_ctl.clear ? '0 : wr_data;

   always_comb begin
      for (int k = 0; k < sib_pkg::NUM_STORES; k++) begin
         we[k] = wr_ctl.clear | wr_ctl.store_we[k];
         // The memory returns the old word when the same entry is written in the
         // read cycle, so the new word is taken from the forwarding register.
         hit_in[k] = wr_ctl.store_we[k] && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < sib_pkg::NUM_STORES; k++) begin
         if (we[k]) begin
            mem[wr_addr][k] <= store_data;
         end
      end
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   for (genvar k = 0; k < sib_pkg::NUM_STORES; k++) begin : g_store
      assign rd_data[k] = hit_ff[k] ? fwd_data_ff : q_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= '0;
      end else if (rd_en) begin
         hit_ff <= hit_in;
      end
      if (rd_en) begin
         fwd_data_ff <= wr_data;
      end
   end

endmodule
`default_nettype wire

// ===== tb/sv/tb_smart_interframe_blend.sv =====
// Self-checking testbench for the smart interframe blend block.
`timescale 1ns / 1ps
module tb_smart_interframe_blend;

   localparam int MODEL_PIXELS = 65536;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PIPE_SLACK = 6;
   localparam int RANDOM_PIXELS = 1730;

   // Register indexes that no register answers to.
   localparam logic [sib_pkg::CSR_INDEX_W-1:0] REG_SPARE_LOW = 2'd2;
   localparam logic [sib_pkg::CSR_INDEX_W-1:0] REG_SPARE_HIGH = 2'd3;

   typedef struct {
      logic [sib_pkg::PIXEL_W-1:0] pixel_out;
      logic                        blended;
      logic                        frame_end;
   } blend_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [sib_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sib_pkg::CSR_DATA_W-1:0] csr_wdata;

   sib_req_if req_ch ();
   sib_rsp_if rsp_ch ();

   smart_interframe_blend #(.MAX_PIXELS(MODEL_PIXELS)) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Shadow copy of the three frame stores and the frame bookkeeping.
   bit [sib_pkg::PIXEL_W-1:0] frame_store [sib_pkg::NUM_STORES][MODEL_PIXELS];
   int unsigned      store_position = 0;
   sib_pkg::phase_type store_phase = sib_pkg::PHASE_A;
   logic [sib_pkg::WIDTH_W-1:0]  model_width = sib_pkg::WIDTH_RESET;
   logic [sib_pkg::HEIGHT_W-1:0] model_height = sib_pkg::HEIGHT_RESET;
   int unsigned      frames_seen = 0;

   blend_result_type expected_pixels[$];
   int unsigned   error_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   pixels_sent = 0;
   int unsigned   burst_left = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int unsigned frame_pixels();
      int unsigned len;
      len = (int'(model_width) + 1) * int'(model_height);
      if (len == 0) len = 1;
      if (len > MODEL_PIXELS) len = MODEL_PIXELS;
      return len;
   endfunction

   // Works out the result for one pixel and advances the shadow stores.
   function automatic blend_result_type predict_blend(input logic [sib_pkg::PIXEL_W-1:0] cur);
      blend_result_type r;
      int unsigned len;
      int unsigned pos;
      int one_idx;
      int two_idx;
      int three_idx;
      logic [sib_pkg::PIXEL_W-1:0] one_ago;
      logic [sib_pkg::PIXEL_W-1:0] two_ago;
      logic [sib_pkg::PIXEL_W-1:0] three_ago;
      logic flicker;
      case (store_phase)
         sib_pkg::PHASE_B: begin
            one_idx = 1; two_idx = 0; three_idx = 2;
         end
         sib_pkg::PHASE_C: begin
            one_idx = 2; two_idx = 1; three_idx = 0;
         end
         default: begin
            one_idx = 0; two_idx = 2; three_idx = 1;
         end
      endcase
      len = frame_pixels();
      pos = store_position;
      // A shrunken frame leaves the position past its end: that pixel closes the frame.
      if (pos >= len) pos = len - 1;
      one_ago = frame_store[one_idx][pos];
      two_ago = frame_store[two_idx][pos];
      three_ago = frame_store[three_idx][pos];
      flicker = (one_ago != two_ago) && (three_ago != cur) &&
                ((cur == two_ago) || (one_ago == three_ago));
      r.pixel_out = flicker ? (((cur & sib_pkg::BLEND_MASK) >> 1) +
                               ((one_ago & sib_pkg::BLEND_MASK) >> 1))
                            : cur;
      r.blended = flicker;
      r.frame_end = (pos == len - 1);
      frame_store[three_idx][pos] = cur;
      if (r.frame_end) begin
         store_position = 0;
         frames_seen++;
         case (store_phase)
            sib_pkg::PHASE_A: store_phase = sib_pkg::PHASE_B;
            sib_pkg::PHASE_B: store_phase = sib_pkg::PHASE_C;
            default: store_phase = sib_pkg::PHASE_A;
         endcase
      end else begin
         store_position = pos + 1;
      end
      return r;
   endfunction

   // Receiver stall pattern, from a mode that is picked anew at random.
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      if (cycle_count % 256 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= 1'($urandom_range(0, 1));
         2: rsp_ch.ready <= (cycle_count % 4 == 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_ch.ready <= 1'b0;
            end else begin
               if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(5, 20);
               rsp_ch.ready <= 1'b1;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      blend_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result transfer: pixel_out %h", rsp_ch.pixel_out);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_ch.pixel_out !== want.pixel_out) begin
               $error("pixel_out: expected %h, got %h", want.pixel_out, rsp_ch.pixel_out);
               error_count++;
            end
            if (rsp_ch.blended !== want.blended) begin
               $error("blended: expected %b, got %b", want.blended, rsp_ch.blended);
               error_count++;
            end
            if (rsp_ch.frame_end !== want.frame_end) begin
               $error("frame_end: expected %b, got %b", want.frame_end, rsp_ch.frame_end);
               error_count++;
            end
         end
      end
   end

   // Called at a rising edge; returns at the edge of the transfer or after the gap.
   task automatic send_pixel(input logic [sib_pkg::PIXEL_W-1:0] value);
      req_ch.valid <= 1'b1;
      req_ch.pixel_in <= value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_pixels.push_back(predict_blend(value));
      pixels_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(0, 25);
      end
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sib_pkg::CSR_INDEX_W-1:0] index,
                            input logic [sib_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         sib_pkg::REG_VISIBLE_WIDTH: model_width = data[sib_pkg::WIDTH_W-1:0];
         sib_pkg::REG_VISIBLE_HEIGHT: model_height = data[sib_pkg::HEIGHT_W-1:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_pixel(32'h0000_0000);
      send_pixel(32'hffff_ffff);
      send_pixel(32'haaaa_aaaa);
      send_pixel(32'h5555_5555);
   endtask

   // The position is left past the end of a two-pixel frame.
   task automatic test_position_beyond_frame();
      drain_results();
      write_reg(sib_pkg::REG_VISIBLE_WIDTH, 9'd1);
      write_reg(sib_pkg::REG_VISIBLE_HEIGHT, 9'd1);
      send_pixel(32'h00c0_ffee);
      send_pixel(32'h8000_0001);
      send_pixel(32'h7f00_00ff);
      send_pixel(32'h0123_4567);
   endtask

   // Height zero gives one-pixel frames, so every pixel rotates the stores.
   task automatic test_zero_height_flicker();
      drain_results();
      write_reg(sib_pkg::REG_VISIBLE_HEIGHT, 9'd0);
      send_pixel(32'hff_ff01_80);
      send_pixel(32'h12_3456_79);
      send_pixel(32'hff_ff01_80);
      send_pixel(32'h12_3456_79);
      send_pixel(32'hff_ff01_80);
      send_pixel(32'h00_fefe_ff);
   endtask

   task automatic test_largest_frame();
      drain_results();
      // Bit 8 of the width data is dropped by the register.
      write_reg(sib_pkg::REG_VISIBLE_WIDTH, 9'h1ff);
      write_reg(sib_pkg::REG_VISIBLE_HEIGHT, 9'd256);
      send_pixel(32'hdead_beef);
      send_pixel(32'h0000_0001);
      drain_results();
      write_reg(sib_pkg::REG_VISIBLE_HEIGHT, 9'h1ff);
      send_pixel(32'hcafe_f00d);
      send_pixel(32'hffff_fffe);
   endtask

   task automatic test_unused_index();
      drain_results();
      write_reg(REG_SPARE_LOW, 9'h000);
      write_reg(REG_SPARE_HIGH, 9'h155);
      send_pixel(32'h1357_9bdf);
   endtask

   // Short frames with a small palette, so that history matches and flicker are common.
   task automatic test_random_frames();
      logic [sib_pkg::PIXEL_W-1:0] palette [3];
      logic [sib_pkg::PIXEL_W-1:0] value;
      int unsigned phase_end;
      int unsigned pick;
      while (pixels_sent < RANDOM_PIXELS) begin
         drain_results();
         pick = $urandom_range(0, 9);
         case (pick)
            0: begin
               write_reg(sib_pkg::REG_VISIBLE_WIDTH, 9'd255);
               write_reg(sib_pkg::REG_VISIBLE_HEIGHT, 9'd1);
            end
            1: begin
               write_reg(sib_pkg::REG_VISIBLE_WIDTH, 9'(($urandom_range(0, 1) << 8)));
               write_reg(sib_pkg::REG_VISIBLE_HEIGHT, 9'd0);
            end
            2: begin
               write_reg(sib_pkg::REG_VISIBLE_WIDTH, 9'($urandom_range(0, 15)));
               write_reg(sib_pkg::REG_VISIBLE_HEIGHT, 9'($urandom_range(1, 4)));
            end
            3: write_reg(sib_pkg::REG_VISIBLE_HEIGHT, 9'($urandom_range(1, 3)));
            default: begin
               write_reg(sib_pkg::REG_VISIBLE_WIDTH, 9'($urandom_range(0, 3)));
               write_reg(sib_pkg::REG_VISIBLE_HEIGHT, 9'($urandom_range(1, 4)));
            end
         endcase
         for (int i = 0; i < 3; i++) begin
            palette[i] = $urandom();
         end
         phase_end = pixels_sent + $urandom_range(20, 120);
         while (pixels_sent < phase_end && pixels_sent < RANDOM_PIXELS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) value = $urandom();
            else if (pick < 5) value = palette[$urandom_range(0, 2)];
            else value = palette[(frames_seen + store_position) % 2];
            send_pixel(value);
            if ($urandom_range(0, 199) == 0) drain_results();
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= sib_pkg::REG_VISIBLE_WIDTH;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.pixel_in <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_position_beyond_frame();
      test_zero_height_flicker();
      test_largest_frame();
      test_unused_index();
      test_random_frames();
      drain_results();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== smart_interframe_blend.f =====
sv/sib_pkg.sv
sv/sib_req_if.sv
sv/sib_rsp_if.sv
sv/sib_history.sv
sv/smart_interframe_blend.sv
tb/sv/tb_smart_interframe_blend.sv
